>>> sv/gql_pkg.sv
// Shared types and constants of the glyph quad layout block.
// Used by the top level, the front, the queue and the back; depends on nothing else.
`default_nettype none

package gql_pkg;

    // Input opcodes, carried on the slave tuser.
    localparam logic [1:0] OP_WRITE = 2'd0;
    localparam logic [1:0] OP_START = 2'd1;
    localparam logic [1:0] OP_PLACE = 2'd2;

    // Command kinds handed from the front part to the back part.
    localparam logic [1:0] KIND_NONE    = 2'd0;
    localparam logic [1:0] KIND_START   = 2'd1;
    localparam logic [1:0] KIND_NEWLINE = 2'd2;
    localparam logic [1:0] KIND_GLYPH   = 2'd3;

    localparam logic [7:0] NEWLINE_CODE = 8'd10;

    // Depth of the command queue between front and back.
    localparam int CMD_DEPTH = 4;
    localparam int CMD_PTR_W = $clog2(CMD_DEPTH);

    // Request payload, laid out as on the slave tdata (first member is the top).
    typedef struct packed {
        logic [7:0]  font_size;
        logic [23:0] start_y;
        logic [23:0] start_x;
        logic [7:0]  glyph_advance;
        logic [7:0]  glyph_offset_y;
        logic [7:0]  glyph_offset_x;
        logic [7:0]  glyph_height;
        logic [7:0]  glyph_width;
        logic [11:0] glyph_src_y;
        logic [11:0] glyph_src_x;
        logic [7:0]  char_code;
    } t_req;

    // One glyph store entry.
    typedef struct packed {
        logic [7:0]  advance;
        logic [7:0]  offset_y;
        logic [7:0]  offset_x;
        logic [7:0]  height;
        logic [7:0]  width;
        logic [11:0] src_y;
        logic [11:0] src_x;
    } t_glyph;

    // Classified command travelling through the queue.
    typedef struct packed {
        logic [1:0]  kind;
        t_glyph      glyph;
        logic [8:0]  row;
        logic [23:0] start_x;
        logic [23:0] start_y;
        logic [15:0] scale;
    } t_cmd;

    // Result payload, laid out as on the master tdata.
    typedef struct packed {
        logic [23:0] dest_h;
        logic [23:0] dest_w;
        logic [23:0] dest_y;
        logic [23:0] dest_x;
        logic [7:0]  source_h;
        logic [7:0]  source_w;
        logic [11:0] source_y;
        logic [11:0] source_x;
    } t_res;

endpackage

`default_nettype wire

>>> sv/glyph_quad_layout_core.sv
// Top level of the glyph quad layout block: front, command queue and back.
// Depends on gql_pkg, gql_front, gql_fifo and gql_back.
//
// Channel   Dir  Handshake                 Payload
// s_axis    in   tvalid / tready           tuser: opcode; tdata: request fields
// m_axis    out  tvalid / tready           tuser: quad_valid; tdata: quad fields
//
// One request is accepted per cycle unless the queue is full and the front
// holds a command; each gives exactly one result. A result passes the glyph
// store read register in the front, then the queue, then the output register
// in the back, which the pen update and the scaling multiplies feed.
// Reset clears the glyph store valid bits, the font metrics, the pen and the
// scale; no clearing pass runs. A stall on the master side fills the
// four-entry queue first and only then holds off the slave side.
`default_nettype none

module glyph_quad_layout_core #(
    parameter int GLYPH_COUNT = 256,
    parameter int DESIGN_SIZE = 68
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_s_axis_tvalid,
    output logic              o_s_axis_tready,
    // Fields from bit 0: char_code[7:0], glyph_src_x[19:8], glyph_src_y[31:20],
    // glyph_width[39:32], glyph_height[47:40], glyph_offset_x[55:48],
    // glyph_offset_y[63:56], glyph_advance[71:64], start_x[95:72],
    // start_y[119:96], font_size[127:120].
    input  wire logic [127:0] i_s_axis_tdata,
    // Fields from bit 0: opcode[1:0].
    input  wire logic [1:0]   i_s_axis_tuser,
    output logic              o_m_axis_tvalid,
    input  wire logic         i_m_axis_tready,
    // Fields from bit 0: source_x[11:0], source_y[23:12], source_w[31:24],
    // source_h[39:32], dest_x[63:40], dest_y[87:64], dest_w[111:88],
    // dest_h[135:112].
    output logic [135:0]      o_m_axis_tdata,
    // Fields from bit 0: quad_valid[0].
    output logic [0:0]        o_m_axis_tuser
);
    import gql_pkg::*;

    t_req w_req;
    t_cmd w_f_cmd;
    t_cmd w_q_cmd;
    t_res w_res;
    logic w_f_valid;
    logic w_q_full;
    logic w_q_valid;
    logic w_q_pop;
    logic w_quad;

    assign w_req = i_s_axis_tdata;

    // The front classifies requests and resolves glyph lookups in order.
    gql_front #(
        .GLYPH_COUNT (GLYPH_COUNT),
        .DESIGN_SIZE (DESIGN_SIZE)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_s_axis_tvalid),
        .o_ready     (o_s_axis_tready),
        .i_opcode    (i_s_axis_tuser),
        .i_req       (w_req),
        .o_cmd_valid (w_f_valid),
        .i_cmd_ready (!w_q_full),
        .o_cmd       (w_f_cmd)
    );

    // The queue lets the front keep accepting while the back waits.
    gql_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_f_valid),
        .i_data  (w_f_cmd),
        .o_full  (w_q_full),
        .o_valid (w_q_valid),
        .i_pop   (w_q_pop),
        .o_data  (w_q_cmd)
    );

    // The back owns the pen and scale and drives the output register.
    gql_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (w_q_valid),
        .o_cmd_pop   (w_q_pop),
        .i_cmd       (w_q_cmd),
        .o_valid     (o_m_axis_tvalid),
        .i_ready     (i_m_axis_tready),
        .o_quad      (w_quad),
        .o_res       (w_res)
    );

    assign o_m_axis_tdata    = w_res;
    assign o_m_axis_tuser[0] = w_quad;

endmodule

`default_nettype wire

>>> sv/gql_front.sv
// Front part: accepts requests, keeps the glyph store and the font metrics,
// and turns each request into a classified command. Depends on gql_pkg.
`default_nettype none

module gql_front #(
    parameter int GLYPH_COUNT = 256,
    parameter int DESIGN_SIZE = 68
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    output logic               o_ready,
    input  wire logic [1:0]    i_opcode,
    input  wire gql_pkg::t_req i_req,
    output logic               o_cmd_valid,
    input  wire logic          i_cmd_ready,
    output gql_pkg::t_cmd      o_cmd
);
    import gql_pkg::*;

    localparam int TableDepth = (GLYPH_COUNT < 256) ? GLYPH_COUNT : 256;
    localparam int IdxW       = $clog2(TableDepth);

    typedef logic [IdxW-1:0] t_idx_map [256];
    typedef logic [15:0]     t_scale_map [256];

    function automatic t_idx_map build_idx_map();
        t_idx_map m;
        for (int i = 0; i < 256; i++) begin
            m[i] = IdxW'(i % GLYPH_COUNT);
        end
        return m;
    endfunction

    function automatic t_scale_map build_scale_map();
        t_scale_map m;
        for (int i = 0; i < 256; i++) begin
            m[i] = 16'((i * 256) / DESIGN_SIZE);
        end
        return m;
    endfunction

    localparam t_idx_map   IDX_MAP   = build_idx_map();
    localparam t_scale_map SCALE_MAP = build_scale_map();

    t_glyph                r_mem [TableDepth];
    t_glyph                r_rd_glyph;
    logic                  r_rd_hit;
    logic [TableDepth-1:0] r_gvalid;
    logic                  r_f_valid;
    logic [1:0]            r_kind;
    logic [8:0]            r_row;
    logic [23:0]           r_start_x;
    logic [23:0]           r_start_y;
    logic [15:0]           r_scale;
    logic [6:0]            r_ascent;
    logic signed [9:0]     r_descent;

    logic                  w_accept;
    logic [IdxW-1:0]       w_idx;
    t_glyph                w_wr;
    logic [1:0]            n_kind;
    logic signed [9:0]     w_low;
    logic [9:0]            w_row;

    assign o_ready  = !r_f_valid || i_cmd_ready;
    assign w_accept = i_valid && o_ready;
    assign w_idx    = IDX_MAP[i_req.char_code];

    assign w_wr = '{advance:  i_req.glyph_advance,
                    offset_y: i_req.glyph_offset_y,
                    offset_x: i_req.glyph_offset_x,
                    height:   i_req.glyph_height,
                    width:    i_req.glyph_width,
                    src_y:    i_req.glyph_src_y,
                    src_x:    i_req.glyph_src_x};

    // Lowest point of the glyph below the baseline.
    assign w_low = $signed({{2{i_req.glyph_offset_y[7]}}, i_req.glyph_offset_y})
                 - $signed({2'b00, i_req.glyph_height});
    assign w_row = {3'b000, r_ascent} - r_descent;

    always_comb begin
        unique case (i_opcode)
            OP_START: n_kind = KIND_START;
            OP_PLACE: n_kind = (i_req.char_code == NEWLINE_CODE) ? KIND_NEWLINE : KIND_GLYPH;
            default:  n_kind = KIND_NONE;
        endcase
    end

    // Glyph store: a write always lands before the next request reads it.
    always_ff @(posedge i_clk) begin
        if (w_accept && i_opcode == OP_WRITE) begin
            r_mem[w_idx] <= w_wr;
        end
        if (w_accept) begin
            r_rd_glyph <= r_mem[w_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_rd_hit  <= r_gvalid[w_idx];
            r_kind    <= n_kind;
            r_row     <= w_row[8:0];
            r_start_x <= i_req.start_x;
            r_start_y <= i_req.start_y;
            r_scale   <= SCALE_MAP[i_req.font_size];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f_valid <= 1'b0;
            r_gvalid  <= '0;
            r_ascent  <= '0;
            r_descent <= '0;
        end else begin
            if (w_accept) begin
                r_f_valid <= 1'b1;
            end else if (i_cmd_ready) begin
                r_f_valid <= 1'b0;
            end
            if (w_accept && i_opcode == OP_WRITE) begin
                r_gvalid[w_idx] <= 1'b1;
                if ($signed(i_req.glyph_offset_y) > $signed({1'b0, r_ascent})) begin
                    r_ascent <= i_req.glyph_offset_y[6:0];
                end
                if (w_low < r_descent) begin
                    r_descent <= w_low;
                end
            end
        end
    end

    assign o_cmd_valid = r_f_valid;
    assign o_cmd = '{kind:    r_kind,
                     glyph:   r_rd_hit ? r_rd_glyph : '0,
                     row:     r_row,
                     start_x: r_start_x,
                     start_y: r_start_y,
                     scale:   r_scale};

endmodule

`default_nettype wire

>>> sv/gql_fifo.sv
// Short command queue between the front and back parts.
// Depends on gql_pkg for the command type and depth.
`default_nettype none

module gql_fifo (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  wire gql_pkg::t_cmd i_data,
    output logic               o_full,
    output logic               o_valid,
    input  wire logic          i_pop,
    output gql_pkg::t_cmd      o_data
);
    import gql_pkg::*;

    t_cmd                 r_buf [CMD_DEPTH];
    logic [CMD_PTR_W-1:0] r_wr_ptr;
    logic [CMD_PTR_W-1:0] r_rd_ptr;
    logic [CMD_PTR_W:0]   r_count;
    logic                 w_push;
    logic                 w_pop;

    assign o_full  = (r_count == (CMD_PTR_W + 1)'(CMD_DEPTH));
    assign o_valid = (r_count != '0);
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && o_valid;
    assign o_data  = r_buf[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_buf[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + 1'b1;
            end else if (w_pop && !w_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

>>> sv/gql_back.sv
// Back part: keeps the pen and the scale, scales glyph metrics and places
// quads into the output register. Depends on gql_pkg.
`default_nettype none

module gql_back (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_cmd_valid,
    output logic               o_cmd_pop,
    input  wire gql_pkg::t_cmd i_cmd,
    output logic               o_valid,
    input  wire logic          i_ready,
    output logic               o_quad,
    output gql_pkg::t_res      o_res
);
    import gql_pkg::*;

    logic [23:0]        r_pen_x;
    logic [23:0]        r_pen_y;
    logic [23:0]        r_line_x;
    logic [15:0]        r_scale;
    logic               r_out_valid;
    logic               r_quad;
    t_res               r_res;

    t_glyph             w_g;
    logic signed [24:0] w_scale_s;
    logic signed [24:0] w_ox_p;
    logic signed [24:0] w_oy_p;
    logic [23:0]        w_w_p;
    logic [23:0]        w_h_p;
    logic [23:0]        w_adv_p;
    logic [23:0]        w_row_p;
    logic               w_pop;
    t_res               n_res;

    assign w_g       = i_cmd.glyph;
    assign w_scale_s = $signed({9'd0, r_scale});
    assign w_ox_p    = $signed({{17{w_g.offset_x[7]}}, w_g.offset_x}) * w_scale_s;
    assign w_oy_p    = $signed({{17{w_g.offset_y[7]}}, w_g.offset_y}) * w_scale_s;
    assign w_w_p     = {16'd0, w_g.width} * {8'd0, r_scale};
    assign w_h_p     = {16'd0, w_g.height} * {8'd0, r_scale};
    assign w_adv_p   = {16'd0, w_g.advance} * {8'd0, r_scale};
    assign w_row_p   = {15'd0, i_cmd.row} * {8'd0, r_scale};

    assign w_pop     = i_cmd_valid && (!r_out_valid || i_ready);
    assign o_cmd_pop = w_pop;

    always_comb begin
        n_res = '0;
        if (i_cmd.kind == KIND_GLYPH) begin
            n_res.source_x = w_g.src_x;
            n_res.source_y = w_g.src_y;
            n_res.source_w = w_g.width;
            n_res.source_h = w_g.height;
            n_res.dest_x   = r_pen_x + w_ox_p[23:0];
            n_res.dest_y   = r_pen_y - w_oy_p[23:0];
            n_res.dest_w   = w_w_p;
            n_res.dest_h   = w_h_p;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_pop) begin
            r_res  <= n_res;
            r_quad <= (i_cmd.kind == KIND_GLYPH);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pen_x     <= '0;
            r_pen_y     <= '0;
            r_line_x    <= '0;
            r_scale     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_pop) begin
                r_out_valid <= 1'b1;
                unique case (i_cmd.kind)
                    KIND_START: begin
                        r_pen_x  <= i_cmd.start_x;
                        r_pen_y  <= i_cmd.start_y;
                        r_line_x <= i_cmd.start_x;
                        r_scale  <= i_cmd.scale;
                    end
                    KIND_NEWLINE: begin
                        r_pen_y <= r_pen_y + w_row_p;
                        r_pen_x <= r_line_x;
                    end
                    KIND_GLYPH: begin
                        r_pen_x <= r_pen_x + w_adv_p;
                    end
                    default: begin
                    end
                endcase
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_valid = r_out_valid;
    assign o_quad  = r_quad;
    assign o_res   = r_res;

endmodule

`default_nettype wire

>>> sv/gql_checker.sv
// Port-level checker for glyph_quad_layout_core, attached by bind.
// Depends only on the top level's ports.
`default_nettype none

module gql_checker (
    input wire logic         i_clk,
    input wire logic         i_rst_n,
    input wire logic         i_s_axis_tvalid,
    input wire logic         o_s_axis_tready,
    input wire logic         o_m_axis_tvalid,
    input wire logic         i_m_axis_tready,
    input wire logic [135:0] o_m_axis_tdata,
    input wire logic [0:0]   o_m_axis_tuser
);
    logic [3:0] r_pending;
    logic       w_in_acc;
    logic       w_out_acc;

    assign w_in_acc  = i_s_axis_tvalid && o_s_axis_tready;
    assign w_out_acc = o_m_axis_tvalid && i_m_axis_tready;

    // Requests accepted whose result has not been taken yet.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending <= '0;
        end else if (w_in_acc && !w_out_acc) begin
            r_pending <= r_pending + 1'b1;
        end else if (w_out_acc && !w_in_acc) begin
            r_pending <= r_pending - 1'b1;
        end
    end

    a_no_orphan_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_out_acc |-> r_pending != 4'd0)
        else $error("result delivered without an outstanding request");

    a_bounded_backlog: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pending <= 4'd6)
        else $error("more requests in flight than the block can hold");

    a_empty_non_quad: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !o_m_axis_tuser[0]) |-> o_m_axis_tdata == '0)
        else $error("non-quad result carries nonzero fields");

    a_zero_width_quad: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tdata[31:24] == 8'd0) |->
            o_m_axis_tdata[111:88] == 24'd0)
        else $error("zero-width glyph gave a nonzero screen width");

    a_hold_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !i_m_axis_tready) |=>
            (o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser)))
        else $error("stalled result changed or dropped");

endmodule

bind glyph_quad_layout_core gql_checker u_gql_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .o_s_axis_tready (o_s_axis_tready),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tuser  (o_m_axis_tuser)
);

`default_nettype wire
